// File: src/pwm_ramp_keyframe_player_unit_assert.svh
// assertion macros shared by the ramp player rtl
`ifndef PWM_RAMP_KEYFRAME_PLAYER_UNIT_ASSERT_SVH
`define PWM_RAMP_KEYFRAME_PLAYER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PRK_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define PRK_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define PRK_ASSERT(lbl, prop)
`define PRK_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: src/prkp_pkg.sv
`timescale 1ns / 1ps
package prkp_pkg;

	localparam int MAX_EVENTS = 16;
	localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int CNT_W = $clog2(MAX_EVENTS + 1);

	localparam int TGT_W = 16;
	localparam int STEP_W = 24;
	localparam int FRAC_W = 8;
	localparam int LVL_W = TGT_W + FRAC_W;
	localparam int SUM_W = TGT_W + 2;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_MIN = 2'd0,
		REG_OFFSET = 2'd1,
		REG_MAX = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [TGT_W-1:0] target;
		logic [STEP_W-1:0] step;
	} event_t;

	typedef struct packed {
		logic kind;
		event_t ev;
	} item_t;

	typedef struct packed {
		logic [TGT_W-1:0] min_level;
		logic [TGT_W-1:0] level_offset;
		logic [TGT_W-1:0] max_level;
	} cfg_t;

	typedef struct packed {
		logic [TGT_W-1:0] pwm_value;
		logic event_done;
	} ramp_res_t;

endpackage

// File: src/pwm_ramp_keyframe_player_unit.sv
`timescale 1ns / 1ps
`include "pwm_ramp_keyframe_player_unit_assert.svh"
// piecewise linear ramp player: start with kind 0 appends an event (target, step) to a
// 16-entry table, kind 1 runs one playback tick; busy stays low, so an item can be
// issued on every clock, and each item gives exactly one result, shown for one cycle
// with valid high; the receiver cannot stall, so results must be captured on the
// cycle they appear. each item passes through the input register and then the
// result register; the level update, compare and output clamp sit in
// one pass between them. min_level, level_offset and max_level are written over the
// apb port at byte addresses 0, 4 and 8 and must only change while no item is in
// flight. the output is the integer part of the 16.8 level plus min_level plus
// level_offset, saturated to max_level; status reports a rejected add (table full) or
// a tick with an empty table
module pwm_ramp_keyframe_player_unit (
	input logic clk,
	input logic arst_n,
	// command side
	input logic start,
	output logic busy,
	input logic kind,
	input logic [prkp_pkg::TGT_W-1:0] target,
	input logic [prkp_pkg::STEP_W-1:0] step,
	// result side
	output logic valid,
	output logic [prkp_pkg::TGT_W-1:0] pwm_value,
	output logic event_done,
	output logic [1:0] status,
	// register port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [prkp_pkg::ADDR_W-1:0] paddr,
	input logic [prkp_pkg::DATA_W-1:0] pwdata,
	output logic [prkp_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	// config registers
	prkp_pkg::cfg_t cfg_q;
	logic cfg_wr;
	prkp_pkg::reg_idx_t reg_idx;

	// input stage
	logic valid_s1;
	prkp_pkg::item_t item_s1;

	// result register
	logic valid_q;
	logic [prkp_pkg::TGT_W-1:0] pwm_q;
	logic done_q;
	prkp_pkg::status_t status_q;

	// datapath between the stages
	logic [prkp_pkg::CNT_W-1:0] count;
	logic [prkp_pkg::IDX_W-1:0] play_idx;
	prkp_pkg::event_t cur_event;
	prkp_pkg::ramp_res_t ramp_res;
	logic is_add;
	logic is_tick;
	logic full;
	logic empty;
	logic add_en;
	logic tick_en;

	// every beat is taken, one per cycle
	assign busy = 1'b0;
	assign pready = 1'b1;

	assign reg_idx = prkp_pkg::reg_idx_t'(paddr[prkp_pkg::ADDR_W-1:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_level <= '0;
			cfg_q.level_offset <= '0;
			cfg_q.max_level <= '1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				prkp_pkg::REG_MIN: cfg_q.min_level <= pwdata[prkp_pkg::TGT_W-1:0];
				prkp_pkg::REG_OFFSET: cfg_q.level_offset <= pwdata[prkp_pkg::TGT_W-1:0];
				prkp_pkg::REG_MAX: cfg_q.max_level <= pwdata[prkp_pkg::TGT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			prkp_pkg::REG_MIN: prdata[prkp_pkg::TGT_W-1:0] = cfg_q.min_level;
			prkp_pkg::REG_OFFSET: prdata[prkp_pkg::TGT_W-1:0] = cfg_q.level_offset;
			prkp_pkg::REG_MAX: prdata[prkp_pkg::TGT_W-1:0] = cfg_q.max_level;
			default: prdata = '0;
		endcase
	end

	// capture the command beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1.kind <= kind;
			item_s1.ev.target <= target;
			item_s1.ev.step <= step;
		end
	end

	assign is_add = valid_s1 && (item_s1.kind == prkp_pkg::KIND_ADD);
	assign is_tick = valid_s1 && (item_s1.kind == prkp_pkg::KIND_TICK);
	assign full = count >= prkp_pkg::CNT_W'(prkp_pkg::MAX_EVENTS);
	assign empty = count == '0;
	assign add_en = is_add && !full;
	assign tick_en = is_tick && !empty;

	prkp_table u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(add_en),
		.wr_event(item_s1.ev),
		.rd_idx(play_idx),
		.rd_event(cur_event),
		.count(count)
	);

	prkp_ramp u_ramp (
		.clk(clk),
		.arst_n(arst_n),
		.tick_en(tick_en),
		.ev(cur_event),
		.count(count),
		.cfg(cfg_q),
		.play_idx(play_idx),
		.res(ramp_res)
	);

	// result register, adds and rejected ticks report zero level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pwm_q <= tick_en ? ramp_res.pwm_value : '0;
			done_q <= tick_en && ramp_res.event_done;
			if (is_add && full) begin
				status_q <= prkp_pkg::ST_FULL;
			end else if (is_tick && empty) begin
				status_q <= prkp_pkg::ST_EMPTY;
			end else begin
				status_q <= prkp_pkg::ST_OK;
			end
		end
	end

	assign valid = valid_q;
	assign pwm_value = pwm_q;
	assign event_done = done_q;
	assign status = status_q;

	`PRK_ASSERT(a_result_follows_item, valid_s1 |=> valid_q)
	`PRK_ASSERT(a_done_is_ok, valid_q && done_q |-> status_q == prkp_pkg::ST_OK)
	`PRK_ASSERT_ALWAYS(a_count_bounded, count <= prkp_pkg::CNT_W'(prkp_pkg::MAX_EVENTS))

endmodule

// File: src/prkp_table.sv
`timescale 1ns / 1ps
module prkp_table (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input prkp_pkg::event_t wr_event,
	input logic [prkp_pkg::IDX_W-1:0] rd_idx,
	output prkp_pkg::event_t rd_event,
	output logic [prkp_pkg::CNT_W-1:0] count
);

	prkp_pkg::event_t events_q [prkp_pkg::MAX_EVENTS];
	logic [prkp_pkg::CNT_W-1:0] count_q;

	// entries carry no reset, only those below the count are read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			events_q[count_q[prkp_pkg::IDX_W-1:0]] <= wr_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign rd_event = events_q[rd_idx];
	assign count = count_q;

endmodule

// File: src/prkp_ramp.sv
`timescale 1ns / 1ps
`include "pwm_ramp_keyframe_player_unit_assert.svh"
module prkp_ramp (
	input logic clk,
	input logic arst_n,
	input logic tick_en,
	input prkp_pkg::event_t ev,
	input logic [prkp_pkg::CNT_W-1:0] count,
	input prkp_pkg::cfg_t cfg,
	output logic [prkp_pkg::IDX_W-1:0] play_idx,
	output prkp_pkg::ramp_res_t res
);

	logic [prkp_pkg::LVL_W-1:0] level_q;
	logic [prkp_pkg::IDX_W-1:0] play_q;
	logic [prkp_pkg::LVL_W-1:0] goal;
	logic [prkp_pkg::LVL_W-1:0] span;
	logic [prkp_pkg::LVL_W-1:0] level_new;
	logic [prkp_pkg::CNT_W-1:0] idx_next;
	logic [prkp_pkg::SUM_W-1:0] sum;
	logic above;
	logic snap;
	logic reached;
	logic wrap;

	// stale index folds back to the first event
	assign play_idx = ({{(prkp_pkg::CNT_W-prkp_pkg::IDX_W){1'b0}}, play_q} >= count)
		? '0 : play_q;

	assign goal = {ev.target, {prkp_pkg::FRAC_W{1'b0}}};
	assign above = level_q > goal;
	assign span = above ? (level_q - goal) : (goal - level_q);
	assign snap = (ev.step == '0) || (span <= ev.step);

	always_comb begin
		if (snap) begin
			level_new = goal;
		end else if (above) begin
			level_new = level_q - ev.step;
		end else begin
			level_new = level_q + ev.step;
		end
	end

	assign reached = level_new == goal;
	assign idx_next = {{(prkp_pkg::CNT_W-prkp_pkg::IDX_W){1'b0}}, play_idx} + 1'b1;
	assign wrap = idx_next >= count;

	// integer part plus both offsets, no wrap, then clamp
	assign sum = {2'b00, level_new[prkp_pkg::LVL_W-1:prkp_pkg::FRAC_W]}
		+ {2'b00, cfg.min_level} + {2'b00, cfg.level_offset};
	assign res.pwm_value = (sum < {2'b00, cfg.max_level})
		? sum[prkp_pkg::TGT_W-1:0] : cfg.max_level;
	assign res.event_done = reached;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			play_q <= '0;
		end else if (tick_en) begin
			if (reached && wrap) begin
				level_q <= '0;
				play_q <= '0;
			end else if (reached) begin
				level_q <= level_new;
				play_q <= idx_next[prkp_pkg::IDX_W-1:0];
			end else begin
				level_q <= level_new;
				play_q <= play_idx;
			end
		end
	end

	`PRK_ASSERT(a_wrap_clears_level, tick_en && reached && wrap |=> level_q == '0 && play_q == '0)
	`PRK_ASSERT(a_idle_holds, !tick_en |=> $stable(level_q) && $stable(play_q))
	`PRK_ASSERT(a_index_in_table, count != '0 |-> play_idx < count)

endmodule

// File: tb/pwm_ramp_keyframe_player_unit_checker.sv
`timescale 1ns / 1ps
module pwm_ramp_keyframe_player_unit_checker
	import prkp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic [TGT_W-1:0] target,
	input logic [STEP_W-1:0] step,
	input logic valid,
	input logic [TGT_W-1:0] pwm_value,
	input logic event_done,
	input logic [1:0] status,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic pready,
	output int fail_count,
	output int pending
);

	typedef struct packed {
		logic [TGT_W-1:0] pwm_value;
		logic event_done;
		status_t status;
	} out_beat_t;

	// shadow of the event table, the playback position and the ramp level
	logic [TGT_W-1:0] ev_target [MAX_EVENTS];
	logic [STEP_W-1:0] ev_step [MAX_EVENTS];
	int unsigned ev_count;
	int unsigned play_pos;
	logic [LVL_W-1:0] level;
	cfg_t cfg;
	out_beat_t due_beats[$];
	int n_fail;

	function automatic out_beat_t ramp_predict(input logic k, input logic [TGT_W-1:0] t,
			input logic [STEP_W-1:0] s);
		out_beat_t b;
		logic [LVL_W-1:0] goal;
		logic [LVL_W-1:0] span;
		logic [LVL_W-1:0] st;
		logic [SUM_W-1:0] sum;
		b = '{pwm_value: '0, event_done: 1'b0, status: ST_OK};
		if (k == KIND_ADD) begin
			if (ev_count >= MAX_EVENTS) begin
				b.status = ST_FULL;
			end else begin
				ev_target[ev_count] = t;
				ev_step[ev_count] = s;
				ev_count++;
			end
		end else if (ev_count == 0) begin
			b.status = ST_EMPTY;
		end else begin
			goal = {ev_target[play_pos], {FRAC_W{1'b0}}};
			st = ev_step[play_pos];
			span = (level > goal) ? level - goal : goal - level;
			if (st == '0 || span <= st)
				level = goal;
			else if (level < goal)
				level = level + st;
			else
				level = level - st;
			sum = SUM_W'(level[LVL_W-1:FRAC_W]) + SUM_W'(cfg.min_level)
				+ SUM_W'(cfg.level_offset);
			b.pwm_value = (sum < SUM_W'(cfg.max_level)) ? sum[TGT_W-1:0] : cfg.max_level;
			if (level == goal) begin
				b.event_done = 1'b1;
				play_pos++;
				if (play_pos >= ev_count) begin
					play_pos = 0;
					level = '0;
				end
			end
		end
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_blk
		out_beat_t want;
		out_beat_t got;
		if (!arst_n) begin
			ev_count = 0;
			play_pos = 0;
			level = '0;
			cfg = '{min_level: '0, level_offset: '0, max_level: '1};
			due_beats.delete();
			n_fail = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result side first: a beat accepted now can only belong to an older item
			if (valid) begin
				got = '{pwm_value: pwm_value, event_done: event_done, status: status_t'(status)};
				if (due_beats.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected result beat: pwm %0h done %0b status %0d",
							got.pwm_value, got.event_done, got.status);
				end else begin
					want = due_beats.pop_front();
					if (got !== want) begin
						n_fail++;
						if (n_fail <= 10)
							$display("result mismatch: pwm %0h/%0h done %0b/%0b status %0d/%0d",
								want.pwm_value, got.pwm_value, want.event_done,
								got.event_done, want.status, status);
					end
				end
			end
			if (start && !busy)
				due_beats.push_back(ramp_predict(kind, target, step));
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_MIN: cfg.min_level = pwdata[TGT_W-1:0];
					REG_OFFSET: cfg.level_offset = pwdata[TGT_W-1:0];
					REG_MAX: cfg.max_level = pwdata[TGT_W-1:0];
					default: ;
				endcase
			end
			fail_count <= n_fail;
			pending <= due_beats.size();
		end
	end

endmodule

// File: tb/pwm_ramp_keyframe_player_unit_tb.sv
`timescale 1ns / 1ps
module pwm_ramp_keyframe_player_unit_tb;
	import prkp_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 11;
	// sender gaps are short and every item answers, since the result side cannot stall
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 550;
	localparam int PHASES = 6;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic kind;
	logic [TGT_W-1:0] target;
	logic [STEP_W-1:0] step;
	logic valid;
	logic [TGT_W-1:0] pwm_value;
	logic event_done;
	logic [1:0] status;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	int fail_count;
	int pending;
	int quiet_cycles;
	// percentage of items preceded by a sender gap
	int idle_pct;
	// adds issued so far; beyond MAX_EVENTS they are all rejected
	int adds_sent;

	pwm_ramp_keyframe_player_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.target(target),
		.step(step),
		.valid(valid),
		.pwm_value(pwm_value),
		.event_done(event_done),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predicts each result beat and compares it with what comes out
	pwm_ramp_keyframe_player_unit_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.target(target),
		.step(step),
		.valid(valid),
		.pwm_value(pwm_value),
		.event_done(event_done),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// watchdog: cycles in which no beat moves on any port
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || valid || (psel && penable && pwrite && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("pwm_ramp_keyframe_player_unit regression: fail");
				$finish;
			end
		end
	end

	// one command beat; an optional gap with start low comes first
	task automatic send_item(input logic k, input logic [TGT_W-1:0] t,
			input logic [STEP_W-1:0] s);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			// junk on the fields while start is low
			kind <= 1'($urandom);
			target <= TGT_W'($urandom);
			step <= STEP_W'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		kind <= k;
		target <= t;
		step <= s;
		do @(posedge clk); while (busy);
		if (k == KIND_ADD)
			adds_sent++;
	endtask

	// drop start and wait until every predicted beat has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic write_reg(input reg_idx_t idx, input logic [TGT_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(DATA_W - TGT_W){1'b0}}, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// registers only change with nothing in flight
	task automatic set_levels(input logic [TGT_W-1:0] mn, input logic [TGT_W-1:0] off,
			input logic [TGT_W-1:0] mx);
		drain();
		write_reg(REG_MIN, mn);
		write_reg(REG_OFFSET, off);
		write_reg(REG_MAX, mx);
	endtask

	// random beat: mostly ticks; adds are likelier while the table fills, rare once it is full
	task automatic send_random_item();
		logic [STEP_W-1:0] s;
		if ($urandom_range(99) < ((adds_sent < MAX_EVENTS) ? 35 : 5)) begin
			if (adds_sent < MAX_EVENTS) begin
				// coarse steps keep one pass over the table short; some are jumps
				s = ($urandom_range(7) == 0) ? '0 : STEP_W'($urandom_range(24'h100000, 24'hFFFFFF));
				send_item(KIND_ADD, TGT_W'($urandom), s);
			end else begin
				send_item(KIND_ADD, TGT_W'($urandom), STEP_W'($urandom));
			end
		end else begin
			send_item(KIND_TICK, TGT_W'($urandom), STEP_W'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_ADD;
		target = '0;
		step = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet_cycles = 0;
		idle_pct = 0;
		adds_sent = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// directed part, register reset values
		// tick with nothing in the table
		send_item(KIND_TICK, 16'hFFFF, 24'hFFFFFF);
		// fractional step: sixteen ticks from zero to level 1, integer part truncated
		send_item(KIND_ADD, 16'h0001, 24'h000010);
		repeat (3) send_item(KIND_TICK, 16'h0000, 24'h000000);
		// adds while playing: level already at target, full-range snap, ramp down, jump
		send_item(KIND_ADD, 16'h0001, 24'h000000);
		send_item(KIND_ADD, 16'hFFFF, 24'hFFFFFF);
		send_item(KIND_ADD, 16'h0000, 24'h0A0000);
		send_item(KIND_ADD, 16'h8000, 24'h000000);
		repeat (14) send_item(KIND_TICK, 16'h0000, 24'h000000);

		// random part: register setting changes per phase, sender gaps cycle through
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_levels(TGT_W'($urandom), TGT_W'($urandom), TGT_W'($urandom));
				1: set_levels(16'h0000, 16'h0000, 16'h0000);
				2: set_levels(16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: set_levels(TGT_W'($urandom), 16'h0000, TGT_W'($urandom));
				4: set_levels(16'h0000, 16'h0000, 16'hFFFF);
				default: set_levels(TGT_W'($urandom_range(255)), TGT_W'($urandom), 16'h8000);
			endcase
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 68;
				default: idle_pct = 6;
			endcase
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
				send_random_item();
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("pwm_ramp_keyframe_player_unit regression: pass");
		else
			$display("pwm_ramp_keyframe_player_unit regression: fail");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/prkp_pkg.sv
src/prkp_table.sv
src/prkp_ramp.sv
src/pwm_ramp_keyframe_player_unit.sv
tb/pwm_ramp_keyframe_player_unit_checker.sv
tb/pwm_ramp_keyframe_player_unit_tb.sv
